// ===== src/glyph_atlas_shelf_allocator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Glyph atlas shelf allocator assertion macros
// Concurrent check wrappers shared by the allocator RTL; ASSERT_OFF drops them.
// ----------------------------------------------------------------------------
`ifndef GLYPH_ATLAS_SHELF_ALLOCATOR_TOP_MACROS_SVH
`define GLYPH_ATLAS_SHELF_ALLOCATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define GASA_ASSERT_IMPL(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("gasa: same-cycle check failed");
// next-cycle implication
`define GASA_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("gasa: next-cycle check failed");
`else
`define GASA_ASSERT_IMPL(label, ck, rn, ante, cons)
`define GASA_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

// ===== src/gasa_pkg.sv =====
// ----------------------------------------------------------------------------
// Glyph atlas shelf allocator package
// Field widths, opcodes and the add/compare unit request/response types.
// ----------------------------------------------------------------------------
package gasa_pkg;

	localparam int CHAR_W      = 16;
	localparam int COORD_W     = 8;
	localparam int SHELF_Y_W   = 9;
	localparam int SUM_W       = 10;
	localparam int OUT_PLANE_W = 2;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_ALLOC  = 1'b1;

	typedef struct packed {
		logic [SHELF_Y_W-1:0] a;
		logic [COORD_W-1:0]   b;
	} gasa_acu_req_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             ge;
	} gasa_acu_rsp_t;

endpackage

// ===== src/gasa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data held when not reading.
// ----------------------------------------------------------------------------
module gasa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/gasa_acu.sv =====
// ----------------------------------------------------------------------------
// Shelf add/compare unit
// Shared adder with a fit test against the plane edge.
// ----------------------------------------------------------------------------
module gasa_acu
	import gasa_pkg::*;
#(
	parameter int LIMIT = 256
) (
	input  gasa_acu_req_t req,
	output gasa_acu_rsp_t rsp
);

	always_comb begin
		rsp.sum = {1'b0, req.a} + {{(SUM_W-COORD_W){1'b0}}, req.b};
		rsp.ge  = (rsp.sum >= SUM_W'(LIMIT));
	end

endmodule

// ===== src/glyph_atlas_shelf_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Glyph atlas shelf allocator
// Glyph rectangle cache over a ring of shelf-packed atlas planes.
// ----------------------------------------------------------------------------
// One item is taken at a time. After reset the entry table is cleared in a
// pass over all CHAR_COUNT entries, during which in_stall stays high. A
// lookup steps through index reduction modulo CHAR_COUNT, a table read and
// the result load. An allocate reduces the index likewise, tests the width
// fit, opens a new shelf if it fails, tests the height fit and writes the
// entry; one that moves to the next plane first walks the table: every entry
// is read and, if it sits on the new plane, cleared through the separate read
// and write ports of the table memory, one entry per cycle. Shelf arithmetic
// runs through one shared add/compare unit, stepped by the sequencer. A
// finished result sits in the output register and the next item is already
// taken while it waits; a second result waits for the register to drain.
// ----------------------------------------------------------------------------
`include "glyph_atlas_shelf_allocator_top_macros.svh"

module glyph_atlas_shelf_allocator_top
	import gasa_pkg::*;
#(
	parameter int CHAR_COUNT  = 65536,
	parameter int PLANE_COUNT = 4,
	parameter int PLANE_SIZE  = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   opcode,
	input  logic [CHAR_W-1:0]      char_index,
	input  logic [COORD_W-1:0]     glyph_width,
	input  logic [COORD_W-1:0]     glyph_height,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   hit,
	output logic [OUT_PLANE_W-1:0] plane,
	output logic [COORD_W-1:0]     atlas_x,
	output logic [COORD_W-1:0]     atlas_y,
	output logic [COORD_W-1:0]     rect_width,
	output logic [COORD_W-1:0]     rect_height,
	output logic                   plane_advanced
);

	// table geometry; entry = {valid, plane, x, y, w, h}
	localparam int AW  = $clog2(CHAR_COUNT);
	localparam int PW  = $clog2(PLANE_COUNT);
	localparam int EW  = 1 + PW + 4*COORD_W;
	localparam int RXW = CHAR_W + 1;          // index reduction width
	localparam int RCW = 33;                  // reciprocal width
	localparam logic [RCW-1:0] RECIP = RCW'((64'd1 << 32) / CHAR_COUNT);
	localparam logic [AW-1:0]  LAST  = AW'(CHAR_COUNT - 1);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_MOD1,
		ST_MOD2,
		ST_MOD3,
		ST_RD,
		ST_RDW,
		ST_FITX,
		ST_NEWSH,
		ST_FITY,
		ST_SWEEP,
		ST_STAIL,
		ST_WRITE
	} state_t;

	state_t state_q;

	// latched item
	logic                 op_q;
	logic [CHAR_W-1:0]    ci_q;
	logic [COORD_W-1:0]   w_q;
	logic [COORD_W-1:0]   h_q;
	logic [RXW-1:0]       q_q;
	logic [RXW-1:0]       r_q;
	logic [AW-1:0]        idx_q;
	logic                 adv_q;

	// shelf state
	logic [COORD_W-1:0]   shelf_x_q;
	logic [SHELF_Y_W-1:0] shelf_y_q;
	logic [COORD_W-1:0]   shelf_h_q;
	logic [PW-1:0]        active_plane_q;

	// clear / sweep walk
	logic [AW-1:0]        cnt_q;
	logic [AW-1:0]        sweep_wa_q;
	logic                 sweep_pend_q;

	// output register
	logic                   out_valid_q;
	logic                   hit_q;
	logic [OUT_PLANE_W-1:0] plane_q;
	logic [COORD_W-1:0]     atlas_x_q;
	logic [COORD_W-1:0]     atlas_y_q;
	logic [COORD_W-1:0]     rect_w_q;
	logic [COORD_W-1:0]     rect_h_q;
	logic                   plane_adv_q;

	logic out_free;
	logic out_load;

	// index reduction datapath
	logic [CHAR_W+RCW-1:0] prod1;
	logic [RXW-1:0]        prod2;
	logic [RXW-1:0]        r_red;

	// table port
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [EW-1:0] rd_data;

	logic                 e_valid;
	logic [PW-1:0]        e_plane;
	logic                 e_on_plane;
	logic [PW+OUT_PLANE_W-1:0] rd_plane_ext;
	logic [PW+OUT_PLANE_W-1:0] wr_plane_ext;

	gasa_acu_req_t acu_req;
	gasa_acu_rsp_t acu_rsp;

	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	// a result is loaded when the lookup read or the allocate write completes
	assign out_load = out_free && ((state_q == ST_RDW) || (state_q == ST_WRITE));

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign plane          = plane_q;
	assign atlas_x        = atlas_x_q;
	assign atlas_y        = atlas_y_q;
	assign rect_width     = rect_w_q;
	assign rect_height    = rect_h_q;
	assign plane_advanced = plane_adv_q;

	// code mod CHAR_COUNT: reciprocal estimate is low by at most one
	assign prod1 = {{RCW{1'b0}}, ci_q} * {{CHAR_W{1'b0}}, RECIP};
	assign prod2 = q_q * RXW'(CHAR_COUNT);
	assign r_red = (r_q >= RXW'(CHAR_COUNT)) ? (r_q - RXW'(CHAR_COUNT)) : r_q;

	assign e_valid      = rd_data[EW-1];
	assign e_plane      = rd_data[EW-2 -: PW];
	assign e_on_plane   = e_valid && (e_plane == active_plane_q);
	assign rd_plane_ext = {{OUT_PLANE_W{1'b0}}, e_plane};
	assign wr_plane_ext = {{OUT_PLANE_W{1'b0}}, active_plane_q};

	// shared add/compare operand select
	always_comb begin
		acu_req = '0;
		case (state_q)
			ST_FITX, ST_WRITE: begin
				acu_req.a = {1'b0, shelf_x_q};
				acu_req.b = w_q;
			end
			ST_NEWSH: begin
				acu_req.a = shelf_y_q;
				acu_req.b = shelf_h_q;
			end
			ST_FITY: begin
				acu_req.a = shelf_y_q;
				acu_req.b = h_q;
			end
			default: begin
				acu_req = '0;
			end
		endcase
	end

	gasa_acu #(
		.LIMIT(PLANE_SIZE)
	) u_acu (
		.req(acu_req),
		.rsp(acu_rsp)
	);

	// table port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = idx_q;
		case (state_q)
			ST_INIT: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q;
			end
			ST_RD: begin
				rd_en = 1'b1;
			end
			ST_SWEEP: begin
				rd_en   = 1'b1;
				rd_addr = cnt_q;
				wr_en   = sweep_pend_q && e_on_plane;
				wr_addr = sweep_wa_q;
			end
			ST_STAIL: begin
				wr_en   = sweep_pend_q && e_on_plane;
				wr_addr = sweep_wa_q;
			end
			ST_WRITE: begin
				wr_en   = out_free;
				wr_data = {1'b1, active_plane_q, shelf_x_q, shelf_y_q[COORD_W-1:0],
					w_q, h_q};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	gasa_ram #(
		.WIDTH(EW),
		.DEPTH(CHAR_COUNT)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// sequencer, shelf state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_INIT;
			cnt_q          <= '0;
			sweep_pend_q   <= 1'b0;
			shelf_x_q      <= '0;
			shelf_y_q      <= '0;
			shelf_h_q      <= '0;
			active_plane_q <= '0;
			adv_q          <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode;
						ci_q    <= char_index;
						w_q     <= glyph_width;
						h_q     <= glyph_height;
						adv_q   <= 1'b0;
						state_q <= ST_MOD1;
					end
				end
				ST_MOD1: begin
					q_q     <= prod1[CHAR_W+RCW-1 -: RXW];
					state_q <= ST_MOD2;
				end
				ST_MOD2: begin
					r_q     <= {1'b0, ci_q} - prod2;
					state_q <= ST_MOD3;
				end
				ST_MOD3: begin
					idx_q <= r_red[AW-1:0];
					if (op_q == OP_LOOKUP) begin
						state_q <= ST_RD;
					end else begin
						state_q <= ST_FITX;
					end
				end
				ST_RD: begin
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					if (out_free) begin
						hit_q       <= e_valid;
						plane_adv_q <= 1'b0;
						if (e_valid) begin
							plane_q   <= rd_plane_ext[OUT_PLANE_W-1:0];
							atlas_x_q <= rd_data[4*COORD_W-1 -: COORD_W];
							atlas_y_q <= rd_data[3*COORD_W-1 -: COORD_W];
							rect_w_q  <= rd_data[2*COORD_W-1 -: COORD_W];
							rect_h_q  <= rd_data[COORD_W-1:0];
						end else begin
							plane_q   <= '0;
							atlas_x_q <= '0;
							atlas_y_q <= '0;
							rect_w_q  <= '0;
							rect_h_q  <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_FITX: begin
					if (acu_rsp.ge) begin
						shelf_x_q <= '0;
						state_q   <= ST_NEWSH;
					end else begin
						state_q <= ST_FITY;
					end
				end
				ST_NEWSH: begin
					shelf_y_q <= acu_rsp.sum[SHELF_Y_W-1:0];
					shelf_h_q <= '0;
					state_q   <= ST_FITY;
				end
				ST_FITY: begin
					if (acu_rsp.ge) begin
						// move on to the next plane and walk the table
						if (active_plane_q == PW'(PLANE_COUNT - 1)) begin
							active_plane_q <= '0;
						end else begin
							active_plane_q <= active_plane_q + PW'(1);
						end
						shelf_x_q    <= '0;
						shelf_y_q    <= '0;
						shelf_h_q    <= '0;
						adv_q        <= 1'b1;
						cnt_q        <= '0;
						sweep_pend_q <= 1'b0;
						state_q      <= ST_SWEEP;
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_SWEEP: begin
					sweep_wa_q   <= cnt_q;
					sweep_pend_q <= 1'b1;
					cnt_q        <= cnt_q + AW'(1);
					if (cnt_q == LAST) begin
						state_q <= ST_STAIL;
					end
				end
				ST_STAIL: begin
					sweep_pend_q <= 1'b0;
					state_q      <= ST_WRITE;
				end
				ST_WRITE: begin
					if (out_free) begin
						shelf_x_q <= acu_rsp.sum[COORD_W-1:0];
						if (h_q > shelf_h_q) begin
							shelf_h_q <= h_q;
						end
						hit_q       <= 1'b1;
						plane_q     <= wr_plane_ext[OUT_PLANE_W-1:0];
						atlas_x_q   <= shelf_x_q;
						atlas_y_q   <= shelf_y_q[COORD_W-1:0];
						rect_w_q    <= w_q;
						rect_h_q    <= h_q;
						plane_adv_q <= adv_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a plane advance always places the glyph at the top left corner
	`GASA_ASSERT_IMPL(a_adv_corner, clk, arst_n, out_valid && plane_advanced, hit && (atlas_x == '0) && (atlas_y == '0))
	// a miss reports an all-zero rectangle and no advance
	`GASA_ASSERT_IMPL(a_miss_zero, clk, arst_n, out_valid && !hit, (rect_width == '0) && (rect_height == '0) && !plane_advanced)
	// between items the shelf row lies on the plane and the plane is in the ring
	`GASA_ASSERT_IMPL(a_idle_shelf, clk, arst_n, state_q == ST_IDLE, (shelf_y_q < SHELF_Y_W'(PLANE_SIZE)) && ({1'b0, active_plane_q} < (PW+1)'(PLANE_COUNT)))
	// a failed height fit resets the shelf and starts the eviction walk
	`GASA_ASSERT_NEXT(a_adv_sweep, clk, arst_n, (state_q == ST_FITY) && acu_rsp.ge, (state_q == ST_SWEEP) && (shelf_x_q == '0) && (shelf_y_q == '0) && (cnt_q == '0))

endmodule
